>>> src/bsm_pkg.sv
package bsm_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned OPND_MAX_W = 2 * WORD_W;
  localparam int unsigned PROD_W    = 4 * WORD_W;

  typedef struct packed {
    logic signed [WORD_W-1:0] multiplicand_hi;
    logic        [WORD_W-1:0] multiplicand_lo;
    logic signed [WORD_W-1:0] multiplier_hi;
    logic        [WORD_W-1:0] multiplier_lo;
  } bsm_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] product_w3;
    logic        [WORD_W-1:0] product_w2;
    logic        [WORD_W-1:0] product_w1;
    logic        [WORD_W-1:0] product_w0;
  } bsm_out_t;

endpackage

>>> src/booth_signed_multiplier_128.sv
// Signed radix-2 Booth multiplier, OPERAND_WIDTH x OPERAND_WIDTH bits.
// The input channel (in_valid, in_stall, in_data) carries a multiplicand and
// a multiplier, each as two 64-bit halves; only their low OPERAND_WIDTH bits
// are used, read as two's complement. The output channel (out_valid, out_stall,
// out_data) returns the 2*OPERAND_WIDTH-bit product sign-extended to 256 bits.
// The datapath is a chain of OPERAND_WIDTH identical cells, one Booth step
// each. A transaction accepted at the input passes through every cell in
// order and can then be taken from the output of the last cell.
// A new transaction is accepted every cycle while in_stall is low.
// The last cell is the output register. When out_valid is high and out_stall
// is asserted, the whole chain freezes and in_stall is raised; otherwise the
// chain advances and in_stall is low, even while results are in flight.
// A multiplicand of -2^(OPERAND_WIDTH-1) gives the wrapped Booth value,
// since the accumulator is OPERAND_WIDTH bits wide.
// Reset clears the valid bit of every cell; data registers are not reset.
module booth_signed_multiplier_128 import bsm_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bsm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bsm_out_t out_data
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic                  en;
  logic [W:0]            vld_s;
  logic [W-1:0]          a_s  [0:W];
  logic [W-1:0]          q_s  [0:W];
  logic [W:0]            q1_s;
  logic [W-1:0]          m_s  [0:W];
  logic [OPND_MAX_W-1:0] mcand_full;
  logic [OPND_MAX_W-1:0] mplier_full;
  logic signed [2*W-1:0] prod_pair;
  logic [PROD_W-1:0]     prod;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign mcand_full  = {in_data.multiplicand_hi, in_data.multiplicand_lo};
  assign mplier_full = {in_data.multiplier_hi, in_data.multiplier_lo};

  assign vld_s[0] = in_valid;
  assign a_s[0]   = '0;
  assign q_s[0]   = mplier_full[W-1:0];
  assign q1_s[0]  = 1'b0;
  assign m_s[0]   = mcand_full[W-1:0];

  for (genvar i = 0; i < W; i++) begin : g_cell
    bsm_cell #(.W(W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_in (vld_s[i]),
      .a_in   (a_s[i]),
      .q_in   (q_s[i]),
      .q1_in  (q1_s[i]),
      .m_in   (m_s[i]),
      .vld_r  (vld_s[i+1]),
      .a_r    (a_s[i+1]),
      .q_r    (q_s[i+1]),
      .q1_r   (q1_s[i+1]),
      .m_r    (m_s[i+1])
    );
  end

  assign prod_pair = {a_s[W], q_s[W]};
  assign prod      = PROD_W'(prod_pair);
  assign out_valid = vld_s[W];

  always_comb begin
    out_data.product_w3 = prod[4*WORD_W-1:3*WORD_W];
    out_data.product_w2 = prod[3*WORD_W-1:2*WORD_W];
    out_data.product_w1 = prod[2*WORD_W-1:WORD_W];
    out_data.product_w0 = prod[WORD_W-1:0];
  end

  // A frozen chain keeps every transaction in its cell.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_s[W:1]))
    else $error("cell valid bits moved while the chain was stalled");

  // A zero multiplicand never disturbs the accumulator, so the product is zero.
  a_zero_mcand: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (m_s[W] == '0) |-> (prod == '0))
    else $error("nonzero product for a zero multiplicand");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && (vld_s[W:1] == '0))
    else $error("cells hold valid transactions after reset");

endmodule

>>> src/bsm_cell.sv
module bsm_cell import bsm_pkg::*; #(
  parameter int unsigned W = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_in,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] q_in,
  input  logic         q1_in,
  input  logic [W-1:0] m_in,
  output logic         vld_r,
  output logic [W-1:0] a_r,
  output logic [W-1:0] q_r,
  output logic         q1_r,
  output logic [W-1:0] m_r
);

  logic [W-1:0] sum;
  logic [W-1:0] a_nxt;
  logic [W-1:0] q_nxt;

  // One Booth step: the bit pair (q0, q1) picks subtract, add or hold; the
  // accumulator wraps within W bits, then {A,Q} shifts right arithmetically.
  always_comb begin
    unique case ({q_in[0], q1_in})
      2'b10:   sum = a_in - m_in;
      2'b01:   sum = a_in + m_in;
      default: sum = a_in;
    endcase
    a_nxt = {sum[W-1], sum[W-1:1]};
    q_nxt = {sum[0], q_in[W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      q_r  <= q_nxt;
      q1_r <= q_in[0];
      m_r  <= m_in;
    end
  end

endmodule
